FILE: src/qeps_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler
// pose shift pipeline. No dependencies; every module of the block imports it.
package qeps_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NSTG          = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int SQ_CELLS      = 29;

    // Vectoring lanes: vector and angle widths. Rotation lane: vector and angle widths.
    localparam int VW = 37;
    localparam int ZW = 34;
    localparam int RW = 49;
    localparam int AW = 35;
    localparam int SW = 58;

    localparam logic signed [ZW-1:0] ANG_PI_2 = 34'sd1686629713;
    localparam logic signed [15:0]   Q13_PI   = 16'sd25736;
    localparam logic signed [15:0]   Q13_PI_2 = 16'sd12868;
    localparam logic [29:0]          GAIN_INV = 30'd652032874;
    localparam logic [15:0]          OFFSET_RESET = 16'd384;

    localparam logic [31:0] ATAN_TAB [24] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127
    };

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_vec;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [AW-1:0] a;
    } t_rot;

    typedef struct packed {
        logic [SW-1:0] n;
        logic [SW-1:0] r;
    } t_sqrt;

    // Moves a vector in the left half plane into the right half plane.
    function automatic t_vec vec_prerot(input logic signed [33:0] y,
                                        input logic signed [33:0] x);
        t_vec v;
        logic signed [VW-1:0] xe;
        logic signed [VW-1:0] ye;
        xe = VW'(x);
        ye = VW'(y);
        v.zero = (x == 34'sd0) && (y == 34'sd0);
        if (x < 0) begin
            if (y >= 0) begin
                v.x = ye;
                v.y = -xe;
                v.z = ANG_PI_2;
            end else begin
                v.x = -ye;
                v.y = xe;
                v.z = -ANG_PI_2;
            end
        end else begin
            v.x = xe;
            v.y = ye;
            v.z = '0;
        end
        return v;
    endfunction

    // Rounds a 2^-30 rad angle half up to Q3.13 and clamps it to +-lim.
    function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
                                                  input logic signed [15:0] lim);
        logic signed [ZW:0] s;
        logic signed [ZW:0] q;
        logic signed [15:0] res;
        s = (ZW+1)'(a) + (ZW+1)'(65536);
        q = s >>> 17;
        if (q > lim) begin
            res = lim;
        end else if (q < -lim) begin
            res = -lim;
        end else begin
            res = 16'(q);
        end
        return res;
    endfunction

endpackage

FILE: src/qeps_sqrt_cell.sv
// One digit cell of the pipelined integer square root: one result bit per cell.
// Depends on qeps_pkg for the t_sqrt record.
module qeps_sqrt_cell import qeps_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_bit,
    input  t_sqrt         i_sq,
    output t_sqrt         o_sq
);
    t_sqrt         r_sq;
    t_sqrt         n_sq;
    logic [SW-1:0] trial;

    always_comb begin
        trial = i_sq.r + i_bit;
        if (i_sq.n >= trial) begin
            n_sq.n = i_sq.n - trial;
            n_sq.r = (i_sq.r >> 1) + i_bit;
        end else begin
            n_sq.n = i_sq.n;
            n_sq.r = i_sq.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

FILE: src/qeps_vec_cell.sv
// One vectoring CORDIC micro-rotation cell; drives y toward zero and sums angle.
// Depends on qeps_pkg for the t_vec record.
module qeps_vec_cell import qeps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [4:0]  i_shift,
    input  logic [31:0] i_atan,
    input  t_vec        i_vec,
    output t_vec        o_vec
);
    t_vec                 r_vec;
    t_vec                 n_vec;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [ZW-1:0] da;

    always_comb begin
        dx    = i_vec.y >>> i_shift;
        dy    = i_vec.x >>> i_shift;
        da    = $signed(ZW'(i_atan));
        n_vec = i_vec;
        if (i_vec.y > 0) begin
            n_vec.x = i_vec.x + dx;
            n_vec.y = i_vec.y - dy;
            n_vec.z = i_vec.z + da;
        end else begin
            n_vec.x = i_vec.x - dx;
            n_vec.y = i_vec.y + dy;
            n_vec.z = i_vec.z - da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

FILE: src/qeps_rot_cell.sv
// One rotation-mode CORDIC micro-rotation cell; drives the residual angle to zero.
// Depends on qeps_pkg for the t_rot record.
module qeps_rot_cell import qeps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [4:0]  i_shift,
    input  logic [31:0] i_atan,
    input  t_rot        i_rot,
    output t_rot        o_rot
);
    t_rot                 r_rot;
    t_rot                 n_rot;
    logic signed [RW-1:0] dx;
    logic signed [RW-1:0] dy;
    logic signed [AW-1:0] da;

    always_comb begin
        dx = i_rot.y >>> i_shift;
        dy = i_rot.x >>> i_shift;
        da = $signed(AW'(i_atan));
        if (i_rot.a >= 0) begin
            n_rot.x = i_rot.x - dx;
            n_rot.y = i_rot.y + dy;
            n_rot.a = i_rot.a - da;
        end else begin
            n_rot.x = i_rot.x + dx;
            n_rot.y = i_rot.y - dy;
            n_rot.a = i_rot.a + da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

FILE: src/quaternion_euler_pose_shift_core.sv
// The square root (29 cells) and the two CORDIC chains are fully pipelined, so
// a new request enters every cycle while the output is taken; a held output
// stalls the whole pipeline. Synchronous active-low reset clears the valid
// bits and sets rear_offset to 384.
module quaternion_euler_pose_shift_core import qeps_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, pos_x, pos_y
    input  logic [111:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // roll_angle, pitch_angle, heading_angle, shifted_x, shifted_y, zero pad
    output logic [95:0]  o_m_axis_tdata,
    // pitch_clamped
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [15:0]  i_cfg_data
);
    localparam int LAT = 37 + 2 * NSTG;

    typedef struct packed {
        logic signed [33:0] sr;
        logic signed [33:0] cr;
        logic signed [33:0] sy;
        logic signed [33:0] cy;
        logic signed [28:0] sp;
        logic               clamped;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } t_sqs;

    typedef struct packed {
        logic               clamped;
        logic               sp_neg;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } t_vs;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } t_rs;

    logic               en;
    logic               r_vld [LAT];
    logic [15:0]        r_rear_offset;

    // Stage 1: products.
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    logic signed [23:0] r_px1, r_py1;
    logic signed [15:0] in_w, in_x, in_y, in_z;

    // Stages 2 to 4: ZYX terms, square, radicand.
    t_sqs               r_s2, r_s3, r_s4;
    t_sqs               n_s2;
    logic signed [57:0] n_sq;
    logic [SW-1:0]      r_sq;
    logic [SW-1:0]      r_rad;

    t_sqrt              w_sq [SQ_CELLS+1];
    t_sqs               r_sqd [SQ_CELLS];

    t_vec               w_roll [NSTG+1];
    t_vec               w_pitch [NSTG+1];
    t_vec               w_yaw [NSTG+1];
    t_vec               r_pre_roll, r_pre_pitch, r_pre_yaw;
    t_vs                r_vsd [NSTG+1];
    t_sqs               sq_last;
    logic [28:0]        sqrt_c;

    t_rs                r_rnd;
    t_rs                n_rnd;
    t_rot               w_rot [NSTG+1];
    t_rot               r_pre_rot;
    t_rot               n_pre_rot;
    t_rs                r_rsd [NSTG+1];
    logic [45:0]        mag;
    logic signed [AW-1:0] yaw_ang;

    logic signed [RW-1:0] ox, oy, dx_pos, dy_pos;
    logic signed [23:0] sx, sy;
    logic [95:0]        r_tdata;
    logic               r_tuser;

    assign en              = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_tuser;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rear_offset <= OFFSET_RESET;
        end else if (i_cfg_valid) begin
            r_rear_offset <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign in_w = $signed(i_s_axis_tdata[15:0]);
    assign in_x = $signed(i_s_axis_tdata[31:16]);
    assign in_y = $signed(i_s_axis_tdata[47:32]);
    assign in_z = $signed(i_s_axis_tdata[63:48]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx  <= in_w * in_x;
            r_yz  <= in_y * in_z;
            r_xx  <= in_x * in_x;
            r_yy  <= in_y * in_y;
            r_wy  <= in_w * in_y;
            r_zx  <= in_z * in_x;
            r_wz  <= in_w * in_z;
            r_xy  <= in_x * in_y;
            r_zz  <= in_z * in_z;
            r_px1 <= $signed(i_s_axis_tdata[87:64]);
            r_py1 <= $signed(i_s_axis_tdata[111:88]);
        end
    end

    logic signed [33:0] sp_full;

    always_comb begin
        sp_full    = (34'(r_wy) - 34'(r_zx)) <<< 1;
        n_s2.sr    = (34'(r_wx) + 34'(r_yz)) <<< 1;
        n_s2.cr    = 34'sd268435456 - ((34'(r_xx) + 34'(r_yy)) <<< 1);
        n_s2.sy    = (34'(r_wz) + 34'(r_xy)) <<< 1;
        n_s2.cy    = 34'sd268435456 - ((34'(r_yy) + 34'(r_zz)) <<< 1);
        // The sine term saturates pitch once its magnitude reaches one.
        n_s2.clamped = (sp_full >= 34'sd268435456) || (sp_full <= -34'sd268435456);
        // A clamped term keeps only its sign, which picks the saturated pitch.
        n_s2.sp    = n_s2.clamped ? {sp_full[33], 28'd0} : sp_full[28:0];
        n_s2.px    = r_px1;
        n_s2.py    = r_py1;
    end

    assign n_sq = r_s2.sp * r_s2.sp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2  <= n_s2;
            r_s3  <= r_s2;
            r_sq  <= n_sq;
            r_s4  <= r_s3;
            r_rad <= r_s3.clamped ? '0 : ((SW'(1) << 56) - r_sq);
        end
    end

    assign w_sq[0].n = r_rad;
    assign w_sq[0].r = '0;

    genvar gk;
    generate
        for (gk = 0; gk < SQ_CELLS; gk++) begin : g_sqrt
            qeps_sqrt_cell u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_bit (SW'(1) << (2 * (SQ_CELLS - 1 - gk))),
                .i_sq  (w_sq[gk]),
                .o_sq  (w_sq[gk+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqd[0] <= r_s4;
            for (int k = 1; k < SQ_CELLS; k++) begin
                r_sqd[k] <= r_sqd[k-1];
            end
        end
    end

    assign sq_last = r_sqd[SQ_CELLS-1];
    assign sqrt_c  = w_sq[SQ_CELLS].r[28:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre_roll  <= vec_prerot(sq_last.sr, sq_last.cr);
            r_pre_pitch <= vec_prerot(34'(sq_last.sp), $signed(34'(sqrt_c)));
            r_pre_yaw   <= vec_prerot(sq_last.sy, sq_last.cy);
            r_vsd[0].clamped <= sq_last.clamped;
            r_vsd[0].sp_neg  <= sq_last.sp[28];
            r_vsd[0].px      <= sq_last.px;
            r_vsd[0].py      <= sq_last.py;
            for (int k = 1; k <= NSTG; k++) begin
                r_vsd[k] <= r_vsd[k-1];
            end
        end
    end

    assign w_roll[0]  = r_pre_roll;
    assign w_pitch[0] = r_pre_pitch;
    assign w_yaw[0]   = r_pre_yaw;

    generate
        for (gk = 0; gk < NSTG; gk++) begin : g_vec
            qeps_vec_cell u_roll (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_shift (5'(gk)),
                .i_atan  (ATAN_TAB[gk]),
                .i_vec   (w_roll[gk]),
                .o_vec   (w_roll[gk+1])
            );
            qeps_vec_cell u_pitch (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_shift (5'(gk)),
                .i_atan  (ATAN_TAB[gk]),
                .i_vec   (w_pitch[gk]),
                .o_vec   (w_pitch[gk+1])
            );
            qeps_vec_cell u_yaw (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_shift (5'(gk)),
                .i_atan  (ATAN_TAB[gk]),
                .i_vec   (w_yaw[gk]),
                .o_vec   (w_yaw[gk+1])
            );
        end
    endgenerate

    always_comb begin
        n_rnd.roll = w_roll[NSTG].zero ? 16'sd0 : to_q13(w_roll[NSTG].z, Q13_PI);
        n_rnd.yaw  = w_yaw[NSTG].zero ? 16'sd0 : to_q13(w_yaw[NSTG].z, Q13_PI);
        if (r_vsd[NSTG].clamped) begin
            n_rnd.pitch = r_vsd[NSTG].sp_neg ? -Q13_PI_2 : Q13_PI_2;
        end else if (w_pitch[NSTG].zero) begin
            n_rnd.pitch = 16'sd0;
        end else begin
            n_rnd.pitch = to_q13(w_pitch[NSTG].z, Q13_PI_2);
        end
        n_rnd.clamped = r_vsd[NSTG].clamped;
        n_rnd.px      = r_vsd[NSTG].px;
        n_rnd.py      = r_vsd[NSTG].py;
    end

    // The start magnitude carries the gain reciprocal so the result needs no gain correction.
    always_comb begin
        mag     = r_rear_offset * GAIN_INV;
        yaw_ang = AW'(r_rnd.yaw) <<< 17;
        if (yaw_ang > ANG_PI_2) begin
            n_pre_rot.x = '0;
            n_pre_rot.y = $signed(RW'(mag));
            n_pre_rot.a = yaw_ang - AW'(ANG_PI_2);
        end else if (yaw_ang < -ANG_PI_2) begin
            n_pre_rot.x = '0;
            n_pre_rot.y = -$signed(RW'(mag));
            n_pre_rot.a = yaw_ang + AW'(ANG_PI_2);
        end else begin
            n_pre_rot.x = $signed(RW'(mag));
            n_pre_rot.y = '0;
            n_pre_rot.a = yaw_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnd     <= n_rnd;
            r_pre_rot <= n_pre_rot;
            r_rsd[0]  <= r_rnd;
            for (int k = 1; k <= NSTG; k++) begin
                r_rsd[k] <= r_rsd[k-1];
            end
        end
    end

    assign w_rot[0] = r_pre_rot;

    generate
        for (gk = 0; gk < NSTG; gk++) begin : g_rot
            qeps_rot_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_shift (5'(gk)),
                .i_atan  (ATAN_TAB[gk]),
                .i_rot   (w_rot[gk]),
                .o_rot   (w_rot[gk+1])
            );
        end
    endgenerate

    always_comb begin
        ox     = (w_rot[NSTG].x + RW'(64'sd536870912)) >>> 30;
        oy     = (w_rot[NSTG].y + RW'(64'sd536870912)) >>> 30;
        dx_pos = RW'(r_rsd[NSTG].px) - ox;
        dy_pos = RW'(r_rsd[NSTG].py) - oy;
        if (dx_pos > RW'(64'sd8388607)) begin
            sx = 24'sd8388607;
        end else if (dx_pos < -RW'(64'sd8388608)) begin
            sx = -24'sd8388608;
        end else begin
            sx = 24'(dx_pos);
        end
        if (dy_pos > RW'(64'sd8388607)) begin
            sy = 24'sd8388607;
        end else if (dy_pos < -RW'(64'sd8388608)) begin
            sy = -24'sd8388608;
        end else begin
            sy = 24'(dy_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= {1'b0, sy, sx, r_rsd[NSTG].yaw, r_rsd[NSTG].pitch[14:0],
                        r_rsd[NSTG].roll};
            r_tuser <= r_rsd[NSTG].clamped;
        end
    end

endmodule
